// ===== hdl/pvm_pkg.sv =====
// types and constants shared by the pike vm regex matcher
`timescale 1ns / 1ps
package pvm_pkg;

  localparam int REG_INDEX_W = 3;
  localparam int REG_DATA_W = 8;
  localparam int PROG_WORD_W = 23;
  localparam int CLASS_BITS = 256;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLASS = 2'd1,
    CMD_START = 2'd2,
    CMD_CHAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_CHAR   = 3'd0,
    OP_ANY    = 3'd1,
    OP_SOL    = 3'd2,
    OP_EOL    = 3'd3,
    OP_SET    = 3'd4,
    OP_SPLIT  = 3'd5,
    OP_JMP    = 3'd6,
    OP_ACCEPT = 3'd7
  } opcode_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_CASE_INS  = 3'd0,
    REG_MULTILINE = 3'd1,
    REG_STOP      = 3'd2,
    REG_SEARCH    = 3'd3,
    REG_END_CHAR  = 3'd4,
    REG_PROG_LEN  = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CLS_RD,
    ST_CLS_WR,
    ST_START,
    ST_CHAR,
    ST_FETCH,
    ST_DECODE,
    ST_EXEC,
    ST_EXEC2,
    ST_PASS_END,
    ST_RESULT
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  addr;
    opcode_t     opcode;
    logic [7:0]  char_value;
    logic [5:0]  target_x;
    logic [5:0]  target_y;
  } req_t;

  typedef struct packed {
    logic        done_res;
    logic        matched;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic [15:0] chars_seen;
  } res_t;

  typedef struct packed {
    logic       case_insensitive;
    logic       multiline;
    logic       stop_at_first_match;
    logic       search_mode;
    logic [7:0] end_char;
    logic [6:0] program_length;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic load_prog;
    logic cls_rd;
    logic cls_wr;
    logic start;
    logic char_begin;
    logic list_rd;
    logic instr_rd;
    logic exec;
    logic exec2;
    logic pass_end;
    logic cap;
  } ctrl_cmd_t;

  typedef struct packed {
    logic more;
    logic rerun;
    logic stop_hit;
    logic is_branch;
    logic finished;
  } dp_stat_t;

endpackage

// ===== hdl/pvm_stream_if.sv =====
// valid/ready stream interface carrying one item
`timescale 1ns / 1ps
interface pvm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/pvm_ctrl.sv =====
// sequencer for commands and thread passes
`timescale 1ns / 1ps
module pvm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  pvm_pkg::cmd_t     in_cmd,
  input  logic              out_free,
  input  pvm_pkg::dp_stat_t stat,
  output logic              idle,
  output pvm_pkg::ctrl_cmd_t cmd
);
  import pvm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_cmd)
            CMD_LOAD:  state_next = ST_LOAD;
            CMD_CLASS: state_next = ST_CLS_RD;
            CMD_START: state_next = ST_START;
            CMD_CHAR:  state_next = ST_CHAR;
          endcase
        end
      end
      ST_LOAD:   state_next = ST_RESULT;
      ST_CLS_RD: state_next = ST_CLS_WR;
      ST_CLS_WR: state_next = ST_RESULT;
      ST_START:  state_next = ST_RESULT;
      ST_CHAR:   state_next = stat.finished ? ST_RESULT : ST_FETCH;
      ST_FETCH:  state_next = stat.more ? ST_DECODE : ST_PASS_END;
      ST_DECODE: state_next = ST_EXEC;
      ST_EXEC: begin
        priority if (stat.stop_hit) state_next = ST_RESULT;
        else if (stat.is_branch) state_next = ST_EXEC2;
        else state_next = ST_FETCH;
      end
      ST_EXEC2:    state_next = ST_FETCH;
      ST_PASS_END: state_next = stat.rerun ? ST_FETCH : ST_RESULT;
      ST_RESULT:   state_next = out_free ? ST_IDLE : ST_RESULT;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    idle           = (state == ST_IDLE);
    cmd            = '0;
    cmd.take       = acc;
    cmd.load_prog  = (state == ST_LOAD);
    cmd.cls_rd     = (state == ST_CLS_RD);
    cmd.cls_wr     = (state == ST_CLS_WR);
    cmd.start      = (state == ST_START);
    cmd.char_begin = (state == ST_CHAR) && !stat.finished;
    cmd.list_rd    = (state == ST_FETCH) && stat.more;
    cmd.instr_rd   = (state == ST_DECODE);
    cmd.exec       = (state == ST_EXEC);
    cmd.exec2      = (state == ST_EXEC2);
    cmd.pass_end   = (state == ST_PASS_END);
    cmd.cap        = (state == ST_RESULT) && out_free;
  end

endmodule

// ===== hdl/pvm_dp.sv =====
// thread lists, program and class memories, match counters
`timescale 1ns / 1ps
module pvm_dp #(
  parameter int PROG_DEPTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pvm_pkg::cfg_t      cfg,
  input  pvm_pkg::req_t      req,
  input  pvm_pkg::ctrl_cmd_t cmd,
  output pvm_pkg::dp_stat_t  stat,
  output pvm_pkg::res_t      snap
);
  import pvm_pkg::*;

  localparam int IW = $clog2(PROG_DEPTH);
  localparam int CNTW = $clog2(PROG_DEPTH + 1);
  localparam int VW = (CNTW > 7) ? CNTW : 7;

  function automatic logic [7:0] fold_lc(input logic [7:0] x);
    if (x >= 8'h41 && x <= 8'h5a) return x + 8'd32;
    return x;
  endfunction

  function automatic logic [7:0] swap_lc(input logic [7:0] x);
    if (x >= 8'h41 && x <= 8'h5a) return x + 8'd32;
    if (x >= 8'h61 && x <= 8'h7a) return x - 8'd32;
    return x;
  endfunction

  req_t rq;

  logic [PROG_WORD_W-1:0] prog_mem [PROG_DEPTH];
  logic [CLASS_BITS-1:0]  bm_mem [PROG_DEPTH];
  logic [IW-1:0]          list_mem [2*PROG_DEPTH];
  logic [PROG_DEPTH-1:0]  bm_valid;

  logic [PROG_WORD_W-1:0] prog_q;
  logic [CLASS_BITS-1:0]  bm_q;
  logic                   bm_v_q;
  logic [IW-1:0]          list_q;

  logic [1:0][PROG_DEPTH-1:0] marks;
  logic [1:0][CNTW-1:0]       cnt;
  logic                       cur_sel;
  logic [CNTW-1:0]            t;

  logic [COUNT_WIDTH-1:0] char_counter;
  logic [COUNT_WIDTH-1:0] start_pos;
  logic [COUNT_WIDTH-1:0] end_pos;
  logic [COUNT_WIDTH-1:0] cc_m1;
  logic [7:0]             prev_char;
  logic                   finished;
  logic                   finish_flag;

  logic [VW-1:0] plen;
  logic [VW-1:0] a_ext;
  logic [IW-1:0] a_idx;
  logic          addr_ok;
  logic [IW-1:0] bm_ra;
  logic          bm_re;

  opcode_t       op;
  logic [7:0]    lit;
  logic [5:0]    tx;
  logic [5:0]    ty;
  logic [7:0]    c;
  logic [VW-1:0] v_inc;

  logic          app_en;
  logic          app_next;
  logic [VW-1:0] app_v;
  logic          app_bank;
  logic          app_ok;
  logic          match_op;

  logic          is_end;
  logic          restart;
  logic          list_we;
  logic [IW:0]   list_wa;
  logic [IW-1:0] list_wd;

  // effective program length: zero acts as one, clipped to the memory depth
  always_comb begin
    plen = VW'(cfg.program_length);
    if (cfg.program_length == '0) plen = VW'(1);
    else if (plen > VW'(PROG_DEPTH)) plen = VW'(PROG_DEPTH);
  end

  assign a_ext   = VW'(rq.addr);
  assign a_idx   = a_ext[IW-1:0];
  assign addr_ok = a_ext < VW'(PROG_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.take) rq <= req;
  end

  // program and class memories share one read address
  assign bm_ra = cmd.cls_rd ? a_idx : list_q;
  assign bm_re = cmd.cls_rd || cmd.instr_rd;

  always_ff @(posedge clk) begin
    if (cmd.load_prog && addr_ok) begin
      prog_mem[a_idx] <= {rq.opcode, rq.char_value, rq.target_x, rq.target_y};
    end
    if (cmd.instr_rd) prog_q <= prog_mem[list_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.cls_wr && addr_ok) begin
      bm_mem[a_idx] <= (bm_v_q ? bm_q : '0) | (CLASS_BITS'(1) << rq.char_value);
    end
    if (bm_re) bm_q <= bm_mem[bm_ra];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    if (cmd.list_rd) list_q <= list_mem[{cur_sel, t[IW-1:0]}];
  end

  // instruction decode and thread append
  assign op    = opcode_t'(prog_q[22:20]);
  assign lit   = prog_q[19:12];
  assign tx    = prog_q[11:6];
  assign ty    = prog_q[5:0];
  assign c     = rq.char_value;
  assign v_inc = VW'(list_q) + VW'(1);

  always_comb begin
    app_en   = 1'b0;
    app_next = 1'b0;
    app_v    = v_inc;
    match_op = 1'b0;
    if (cmd.exec) begin
      unique case (op)
        OP_CHAR: begin
          app_en   = cfg.case_insensitive ? (fold_lc(c) == fold_lc(lit)) : (c == lit);
          app_next = 1'b1;
        end
        OP_ANY: begin
          app_en   = 1'b1;
          app_next = 1'b1;
        end
        OP_SOL: begin
          app_en = (char_counter == COUNT_WIDTH'(1)) ||
                   (cfg.multiline && prev_char == NEWLINE_CHAR);
        end
        OP_EOL: begin
          app_en = (c == cfg.end_char) || (cfg.multiline && c == NEWLINE_CHAR);
        end
        OP_SET: begin
          app_en   = bm_v_q && (bm_q[c] || (cfg.case_insensitive && bm_q[swap_lc(c)]));
          app_next = 1'b1;
        end
        OP_SPLIT, OP_JMP: begin
          app_en = 1'b1;
          app_v  = VW'(tx);
        end
        OP_ACCEPT: match_op = 1'b1;
      endcase
    end else if (cmd.exec2) begin
      app_en = 1'b1;
      app_v  = VW'(ty);
    end
  end

  assign app_bank = app_next ? ~cur_sel : cur_sel;
  assign app_ok   = app_en && (app_v < plen) && !marks[app_bank][app_v[IW-1:0]];

  // end of pass decisions
  assign cc_m1   = char_counter - COUNT_WIDTH'(1);
  assign is_end  = (c == cfg.end_char);
  assign restart = !is_end && (cnt[~cur_sel] == '0) && cfg.search_mode && (end_pos == '0);

  assign list_we = app_ok || cmd.start || (cmd.pass_end && restart);
  assign list_wa = app_ok ? {app_bank, cnt[app_bank][IW-1:0]} : {cur_sel, IW'(0)};
  assign list_wd = app_ok ? app_v[IW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks        <= '0;
      cnt          <= '0;
      cur_sel      <= 1'b0;
      t            <= '0;
      char_counter <= '0;
      start_pos    <= '0;
      end_pos      <= '0;
      prev_char    <= '0;
      finished     <= 1'b0;
      finish_flag  <= 1'b0;
      bm_valid     <= '0;
      bm_v_q       <= 1'b0;
    end else begin
      if (bm_re) bm_v_q <= bm_valid[bm_ra];
      if (cmd.load_prog && addr_ok) bm_valid[a_idx] <= 1'b0;
      if (cmd.cls_wr && addr_ok) bm_valid[a_idx] <= 1'b1;

      if (cmd.start) begin
        marks[cur_sel]  <= PROG_DEPTH'(1);
        marks[~cur_sel] <= '0;
        cnt[cur_sel]    <= CNTW'(1);
        cnt[~cur_sel]   <= '0;
        char_counter    <= '0;
        start_pos       <= '0;
        end_pos         <= '0;
        prev_char       <= '0;
        finished        <= 1'b0;
        finish_flag     <= 1'b0;
      end

      if (cmd.char_begin) begin
        if (char_counter != '1) char_counter <= char_counter + COUNT_WIDTH'(1);
        t <= '0;
      end

      if (cmd.list_rd) t <= t + CNTW'(1);

      if (app_ok) begin
        marks[app_bank][app_v[IW-1:0]] <= 1'b1;
        cnt[app_bank]                  <= cnt[app_bank] + CNTW'(1);
      end

      if (match_op) begin
        end_pos <= char_counter;
        if (cfg.stop_at_first_match) begin
          finished    <= 1'b1;
          finish_flag <= 1'b1;
          prev_char   <= c;
        end
      end

      if (cmd.pass_end) begin
        priority if (is_end) begin
          finished    <= 1'b1;
          finish_flag <= 1'b0;
          prev_char   <= c;
        end else if (cnt[~cur_sel] != '0) begin
          marks[cur_sel] <= '0;
          cnt[cur_sel]   <= '0;
          cur_sel        <= ~cur_sel;
          prev_char      <= c;
        end else if (!restart) begin
          finished    <= 1'b1;
          finish_flag <= 1'b1;
          prev_char   <= c;
        end else begin
          marks[cur_sel] <= PROG_DEPTH'(1);
          cnt[cur_sel]   <= CNTW'(1);
          t              <= '0;
          if (cc_m1 != start_pos) begin
            start_pos <= cc_m1;
          end else begin
            start_pos <= char_counter;
            prev_char <= c;
          end
        end
      end
    end
  end

  always_comb begin
    stat.more      = t < cnt[cur_sel];
    stat.rerun     = restart && (cc_m1 != start_pos);
    stat.stop_hit  = match_op && cfg.stop_at_first_match;
    stat.is_branch = (op == OP_SPLIT);
    stat.finished  = finished;
  end

  always_comb begin
    snap.done_res   = finished;
    snap.matched    = finished && finish_flag;
    snap.span_start = 16'(start_pos);
    snap.span_end   = 16'(end_pos);
    snap.chars_seen = 16'(char_counter);
  end

  a_marks_count0: assert property (@(posedge clk) disable iff (rst)
    $countones(marks[0]) == int'(cnt[0]))
    else $error("bank 0 marks disagree with thread count");

  a_marks_count1: assert property (@(posedge clk) disable iff (rst)
    $countones(marks[1]) == int'(cnt[1]))
    else $error("bank 1 marks disagree with thread count");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !finished && char_counter == '0 && cnt[cur_sel] == CNTW'(1))
    else $error("start did not reset the run");

  a_counter_grows: assert property (@(posedge clk) disable iff (rst)
    !cmd.start |=> char_counter >= $past(char_counter))
    else $error("character counter went backwards");

endmodule

// ===== hdl/pike_vm_regex_matcher.sv =====
// top level of the pike vm regex matcher
`timescale 1ns / 1ps
// Thompson-NFA (Pike VM) regex runner. Each request item is a command: load an
// instruction (also clears that instruction's class set), add a class member,
// start a match, or feed one character. Every command returns exactly one result
// item with the run state (done, matched, match start/end, characters seen).
// Items are handled one at a time; request.ready is high while the sequencer is
// idle, and a result may wait in the output register while the next item is
// taken. A character after the run finished goes straight to the result;
// otherwise each live thread is fetched, decoded and executed (a split takes
// a second execute step), and each pass ends with an empty fetch and a
// pass-end step; a search restart adds one more pass. Threads are run one
// after another through the single read port of the thread list and
// program/class memories. No clearing pass is needed after reset: class rows
// and thread marks carry reset flags. Configuration must be written by the
// user through wr_en/wr_index/wr_data only while idle; the block does not enforce it.
module pike_vm_regex_matcher #(
  parameter int PROG_DEPTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  pvm_stream_if.sink                      request,
  pvm_stream_if.source                    result,
  input  logic                            wr_en,
  input  logic [pvm_pkg::REG_INDEX_W-1:0] wr_index,
  input  logic [pvm_pkg::REG_DATA_W-1:0]  wr_data
);
  import pvm_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  res_t      snap;
  res_t      res_q;
  logic      res_valid;
  logic      idle;
  logic      acc;
  logic      out_free;
  req_t      req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.case_insensitive    <= 1'b0;
      cfg.multiline           <= 1'b0;
      cfg.stop_at_first_match <= 1'b0;
      cfg.search_mode         <= 1'b1;
      cfg.end_char            <= '0;
      cfg.program_length      <= 7'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CASE_INS:  cfg.case_insensitive    <= wr_data[0];
        REG_MULTILINE: cfg.multiline           <= wr_data[0];
        REG_STOP:      cfg.stop_at_first_match <= wr_data[0];
        REG_SEARCH:    cfg.search_mode         <= wr_data[0];
        REG_END_CHAR:  cfg.end_char            <= wr_data;
        REG_PROG_LEN:  cfg.program_length      <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  // request side
  assign req           = request.payload;
  assign request.ready = idle;
  assign acc           = request.valid && idle;

  // result register decouples the sequencer from a stalled consumer
  assign out_free       = !res_valid || result.ready;
  assign result.valid   = res_valid;
  assign result.payload = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.cap) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) res_q <= snap;
  end

  pvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .in_cmd   (req.cmd),
    .out_free (out_free),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  pvm_dp #(
    .PROG_DEPTH  (PROG_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .snap (snap)
  );

endmodule
